[sv/modbus_rtu_response_parser_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef MODBUS_RTU_RESPONSE_PARSER_CORE_MACROS_SVH
`define MODBUS_RTU_RESPONSE_PARSER_CORE_MACROS_SVH

// check outside reset
`define MBRTU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define MBRTU_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/mbrtu_pkg.sv]
package mbrtu_pkg;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_FUNC = 4'b0010,
		PH_LEN  = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADFUNC = 2'd1,
		ST_CRC     = 2'd2,
		ST_UNIT    = 2'd3
	} status_t;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] UNIT_RESET = 8'd1;

	localparam logic [7:0] FC_READ_COILS     = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
	localparam logic [7:0] FC_READ_INPUT     = 8'd4;
	localparam logic [7:0] FC_READ_WRITE_MUL = 8'd23;
	localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
	localparam logic [7:0] FC_WRITE_REG      = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

	localparam logic [8:0] LEN_SHORT = 9'd5;
	localparam logic [8:0] LEN_WRITE = 9'd8;
	localparam logic [9:0] CRC_BYTES = 10'd2;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[sv/modbus_rtu_response_parser_core.sv]
// Modbus RTU response parser.
// Input channel: in_valid/in_ready with rx_byte, one received byte per transaction.
// Output channel: out_valid/out_ready with byte_value, byte_position, frame_end,
// is_exception and status; exactly one output transaction per input transaction,
// in order. status is nonzero only on the byte that ends a frame.
// Path: an accepted byte passes through two register stages, the input register
// and then the result register, before it is shown on the output.
// Throughput: one byte per cycle while out_ready is high; the CRC update and frame
// state machine sit in the single combinational pass between the two stages.
// Stall: while out_ready is low the result holds, one more byte waits in the input
// register, and in_ready then drops; nothing is lost.
// Reset (arst_n low): both stages empty, parser idle, CRC at 0xFFFF,
// expected unit back to 1.
// Configuration: cfg_we writes cfg_wdata into the expected unit register at once;
// write only while no frame byte is in flight.
module modbus_rtu_response_parser_core import mbrtu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_value,
	output logic [8:0] byte_position,
	output logic       frame_end,
	output logic       is_exception,
	output logic [1:0] status
);

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        valid_s2;
	logic [7:0]  byte_s2;
	logic [8:0]  pos_s2;
	logic        end_s2;
	logic        exc_s2;
	status_t     status_s2;

	logic [7:0]  expected_unit_q;
	phase_t      phase_q, phase_n;
	logic [8:0]  count_q, count_n;
	logic [8:0]  length_q, length_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  trailer_q, trailer_n;
	logic [7:0]  unit_q, unit_n;
	logic        exc_seen_q, exc_seen_n;

	logic [8:0]  pos_c;
	logic        end_c;
	logic        exc_c;
	status_t     status_c;
	logic [9:0]  pos_plus2;
	logic        advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign pos_plus2 = {1'b0, count_q} + CRC_BYTES;

	always_comb begin
		phase_n    = phase_q;
		count_n    = count_q;
		length_n   = length_q;
		crc_n      = crc_q;
		trailer_n  = trailer_q;
		unit_n     = unit_q;
		exc_seen_n = exc_seen_q;
		pos_c      = count_q;
		end_c      = 1'b0;
		exc_c      = 1'b0;
		status_c   = ST_OK;
		case (phase_q)
			PH_IDLE: begin
				pos_c   = '0;
				unit_n  = rx_byte_s1;
				crc_n   = crc16_byte(CRC_INIT, rx_byte_s1);
				count_n = 9'd1;
				phase_n = PH_FUNC;
			end
			PH_FUNC: begin
				pos_c   = 9'd1;
				crc_n   = crc16_byte(crc_q, rx_byte_s1);
				count_n = 9'd2;
				if (rx_byte_s1[7]) begin
					exc_seen_n = 1'b1;
					exc_c      = 1'b1;
					length_n   = LEN_SHORT;
					phase_n    = PH_DATA;
				end else if (rx_byte_s1 inside {FC_READ_COILS, FC_READ_DISCRETE,
						FC_READ_HOLDING, FC_READ_INPUT, FC_READ_WRITE_MUL}) begin
					length_n = LEN_SHORT;
					phase_n  = PH_LEN;
				end else if (rx_byte_s1 inside {FC_WRITE_COIL, FC_WRITE_REG,
						FC_WRITE_COILS, FC_WRITE_REGS}) begin
					length_n = LEN_WRITE;
					phase_n  = PH_DATA;
				end else begin
					end_c    = 1'b1;
					status_c = ST_BADFUNC;
				end
			end
			PH_LEN: begin
				crc_n    = crc16_byte(crc_q, rx_byte_s1);
				length_n = length_q + {1'b0, rx_byte_s1};
				count_n  = count_q + 9'd1;
				phase_n  = PH_DATA;
			end
			PH_DATA: begin
				exc_c   = exc_seen_q;
				count_n = count_q + 9'd1;
				if (pos_plus2 < {1'b0, length_q}) begin
					crc_n = crc16_byte(crc_q, rx_byte_s1);
				end else if (pos_plus2 == {1'b0, length_q}) begin
					trailer_n = rx_byte_s1;
				end else begin
					end_c = 1'b1;
					if ({rx_byte_s1, trailer_q} != crc_q) begin
						status_c = ST_CRC;
					end else if (unit_q != expected_unit_q) begin
						status_c = ST_UNIT;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
		if (end_c) begin
			phase_n    = PH_IDLE;
			count_n    = '0;
			length_n   = '0;
			crc_n      = CRC_INIT;
			trailer_n  = '0;
			unit_n     = '0;
			exc_seen_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_unit_q <= UNIT_RESET;
		end else if (cfg_we) begin
			expected_unit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= '0;
			length_q   <= '0;
			crc_q      <= CRC_INIT;
			trailer_q  <= '0;
			unit_q     <= '0;
			exc_seen_q <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_n;
			count_q    <= count_n;
			length_q   <= length_n;
			crc_q      <= crc_n;
			trailer_q  <= trailer_n;
			unit_q     <= unit_n;
			exc_seen_q <= exc_seen_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
		if (advance) begin
			byte_s2   <= rx_byte_s1;
			pos_s2    <= pos_c;
			end_s2    <= end_c;
			exc_s2    <= exc_c;
			status_s2 <= status_c;
		end
	end

	assign out_valid     = valid_s2;
	assign byte_value    = byte_s2;
	assign byte_position = pos_s2;
	assign frame_end     = end_s2;
	assign is_exception  = exc_s2;
	assign status        = status_s2;

endmodule

[sv/mbrtu_checker.sv]
`include "modbus_rtu_response_parser_core_macros.svh"

module mbrtu_checker import mbrtu_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte_value,
	input logic [8:0] byte_position,
	input logic       frame_end,
	input logic       is_exception,
	input logic [1:0] status
);

	`MBRTU_ASSERT_ALWAYS(a_empty_in_reset, clk, !arst_n |=> !out_valid, "output valid during reset")

	`MBRTU_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(byte_position) && $stable(status), "stalled output transaction changed")

	`MBRTU_ASSERT(a_status_only_at_end, clk, arst_n, out_valid && !frame_end |-> status == ST_OK, "status set before frame end")

	`MBRTU_ASSERT(a_address_byte, clk, arst_n, out_valid && byte_position == 9'd0 |-> !frame_end && !is_exception, "address byte flagged")

	`MBRTU_ASSERT(a_badfunc_place, clk, arst_n, out_valid && status == ST_BADFUNC |-> frame_end && byte_position == 9'd1, "invalid function reported off the function byte")

endmodule

bind modbus_rtu_response_parser_core mbrtu_checker u_mbrtu_checker (.*);
